>>> rtl/arpt_pkg.sv
// arpt_pkg: shared types, field widths, action and status codes for the
// address range permission table. No dependencies.
package arpt_pkg;

    localparam int ADDR_W            = 64;
    localparam int ACTION_W          = 2;
    localparam int STATUS_W          = 3;
    localparam int TABLE_ENTRIES_DEF = 16;

    typedef logic [ADDR_W-1:0]   addr_t;
    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_PUBLISH  = 2'd0;
    localparam action_t ACT_REVOKE   = 2'd1;
    localparam action_t ACT_VALIDATE = 2'd2;

    localparam status_t ST_OK          = 3'd0;
    localparam status_t ST_BAD_ARGS    = 3'd1;
    localparam status_t ST_OVERLAP     = 3'd2;
    localparam status_t ST_NOT_FOUND   = 3'd3;
    localparam status_t ST_FULL        = 3'd4;
    localparam status_t ST_NOT_COVERED = 3'd5;

    typedef struct packed {
        addr_t range_begin;
        addr_t range_end;
        logic  writable;
    } entry_t;

endpackage

>>> rtl/arpt_req_if.sv
// arpt_req_if: request channel (valid, ready, action payload).
// Depends on arpt_pkg.
interface arpt_req_if;
    import arpt_pkg::*;

    logic    valid;
    logic    ready;
    action_t action;
    addr_t   address;
    addr_t   span_size;
    logic    want_write;

    modport source (output valid, output action, output address, output span_size,
                    output want_write, input ready);
    modport sink   (input valid, input action, input address, input span_size,
                    input want_write, output ready);
endinterface

>>> rtl/arpt_rsp_if.sv
// arpt_rsp_if: response channel (valid, ready, ok and status payload).
// Depends on arpt_pkg.
interface arpt_rsp_if;
    import arpt_pkg::*;

    logic    valid;
    logic    ready;
    logic    ok;
    status_t status;

    modport source (output valid, output ok, output status, input ready);
    modport sink   (input valid, input ok, input status, output ready);
endinterface

>>> rtl/arpt_mem.sv
// arpt_mem: range entry store, one write port and one registered read port.
// Depends on arpt_pkg.
module arpt_mem #(
    parameter int TABLE_ENTRIES = arpt_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_addr,
    input  arpt_pkg::entry_t  wr_data,
    input  logic [IDX_W-1:0]  rd_addr,
    output arpt_pkg::entry_t  rd_data
);
    import arpt_pkg::*;

    entry_t mem [TABLE_ENTRIES];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/arpt_ctrl.sv
// arpt_ctrl: scan sequencer, valid bits and response register.
// Reads every entry through arpt_mem, then writes back on a successful publish.
// Depends on arpt_pkg, arpt_req_if, arpt_rsp_if.
module arpt_ctrl #(
    parameter int TABLE_ENTRIES = arpt_pkg::TABLE_ENTRIES_DEF,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    arpt_req_if.sink          req,
    arpt_rsp_if.source        rsp,
    output logic [IDX_W-1:0]  rd_addr,
    input  arpt_pkg::entry_t  rd_data,
    output logic              wr_en,
    output logic [IDX_W-1:0]  wr_addr,
    output arpt_pkg::entry_t  wr_data
);
    import arpt_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_ENTRIES);

    logic [1:0]               state_reg, state_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;

    action_t    act_reg, act_next;
    addr_t      addr_reg, addr_next;
    addr_t      end_reg, end_next;
    logic       wr_reg, wr_next;
    logic       bad_reg, bad_next;
    logic       overlap_reg, overlap_next;
    logic       free_found_reg, free_found_next;
    logic [IDX_W-1:0] free_idx_reg, free_idx_next;
    logic       hit_reg, hit_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;

    logic       out_valid_reg, out_valid_next;
    logic       ok_reg, ok_next;
    status_t    status_reg, status_next;

    logic [ADDR_W:0] sum;
    logic            span_bad;
    logic            cur_valid;
    logic            ovl, mat, cov, hit_cond;
    logic            can_load;
    status_t         final_status;

    assign req.ready  = (state_reg == S_IDLE);
    assign rsp.valid  = out_valid_reg;
    assign rsp.ok     = ok_reg;
    assign rsp.status = status_reg;

    assign sum      = {1'b0, req.address} + {1'b0, req.span_size};
    assign span_bad = (req.address == '0) || (req.span_size == '0) || sum[ADDR_W];

    assign cur_valid = valid_reg[cmp_idx_reg];
    assign ovl = cur_valid && (addr_reg < rd_data.range_end) && (rd_data.range_begin < end_reg);
    assign mat = cur_valid && (rd_data.range_begin == addr_reg);
    assign cov = cur_valid && (rd_data.range_begin <= addr_reg) && (end_reg <= rd_data.range_end)
                 && (!wr_reg || rd_data.writable);
    assign hit_cond = (act_reg == ACT_REVOKE) ? mat : cov;

    assign can_load = !out_valid_reg || rsp.ready;

    always_comb
    begin
        if (state_reg == S_SCAN && cnt_reg < CNT_LAST)
        begin
            rd_addr = cnt_reg[IDX_W-1:0];
        end
        else
        begin
            rd_addr = '0;
        end
    end

    always_comb
    begin
        final_status = ST_BAD_ARGS;
        if (!bad_reg)
        begin
            unique case (act_reg)
                ACT_PUBLISH:
                begin
                    if (overlap_reg)
                        final_status = ST_OVERLAP;
                    else if (!free_found_reg)
                        final_status = ST_FULL;
                    else
                        final_status = ST_OK;
                end
                ACT_REVOKE:   final_status = hit_reg ? ST_OK : ST_NOT_FOUND;
                ACT_VALIDATE: final_status = hit_reg ? ST_OK : ST_NOT_COVERED;
                default:      final_status = ST_BAD_ARGS;
            endcase
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        valid_next      = valid_reg;
        act_next        = act_reg;
        addr_next       = addr_reg;
        end_next        = end_reg;
        wr_next         = wr_reg;
        bad_next        = bad_reg;
        overlap_next    = overlap_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        ok_next         = ok_reg;
        status_next     = status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        wr_en           = 1'b0;
        wr_addr         = free_idx_reg;
        wr_data         = '{range_begin: addr_reg, range_end: end_reg, writable: wr_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    act_next        = req.action;
                    addr_next       = req.address;
                    end_next        = sum[ADDR_W-1:0];
                    wr_next         = req.want_write;
                    overlap_next    = 1'b0;
                    free_found_next = 1'b0;
                    hit_next        = 1'b0;
                    cnt_next        = CNT_W'(1);
                    unique case (req.action)
                        ACT_PUBLISH:  bad_next = span_bad;
                        ACT_REVOKE:   bad_next = (req.address == '0);
                        ACT_VALIDATE: bad_next = span_bad;
                        default:      bad_next = 1'b1;
                    endcase
                    state_next = bad_next ? S_FINISH : S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (ovl)
                    overlap_next = 1'b1;
                if (!cur_valid && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (hit_cond && !hit_reg)
                begin
                    hit_next     = 1'b1;
                    hit_idx_next = cmp_idx_reg;
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_LAST)
                    state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    ok_next        = (final_status == ST_OK);
                    status_next    = final_status;
                    state_next     = S_IDLE;
                    if (final_status == ST_OK && act_reg == ACT_PUBLISH)
                    begin
                        wr_en                    = 1'b1;
                        valid_next[free_idx_reg] = 1'b1;
                    end
                    if (final_status == ST_OK && act_reg == ACT_REVOKE)
                        valid_next[hit_idx_reg] = 1'b0;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            valid_reg     <= valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmp_idx_reg    <= rd_addr;
        act_reg        <= act_next;
        addr_reg       <= addr_next;
        end_reg        <= end_next;
        wr_reg         <= wr_next;
        bad_reg        <= bad_next;
        overlap_reg    <= overlap_next;
        free_found_reg <= free_found_next;
        free_idx_reg   <= free_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        ok_reg         <= ok_next;
        status_reg     <= status_next;
    end

endmodule

>>> rtl/address_range_permission_table_core.sv
// address_range_permission_table_core: top level of the range permission table.
// Depends on arpt_pkg, arpt_req_if, arpt_rsp_if, arpt_mem, arpt_ctrl.
//
// usage
//   req carries one action per transfer: publish a range, revoke a range by
//   its begin address, or validate an access span against the stored ranges
//   rsp returns one ok/status transfer per request, in request order
//   one item at a time: after a request transfer, req.ready stays low while
//   the sequencer reads every entry of the range memory, one entry a cycle
//   through its single registered read port, then a final step settles the
//   status and writes back
//   the response register is loaded from that final step, and the next
//   request is taken once the sequencer is back in idle; a request with
//   bad arguments skips the scan and goes straight to the final step
//   the response register holds a finished result while rsp.ready is low;
//   the next request is still taken, and its result waits in the final step
//   until the response register frees up
//   reset empties the table at once by clearing the valid bits; the range
//   memory itself is not cleared
module address_range_permission_table_core #(
    parameter int TABLE_ENTRIES = arpt_pkg::TABLE_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    arpt_req_if.sink    req,
    arpt_rsp_if.source  rsp
);
    import arpt_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    entry_t           rd_data;
    entry_t           wr_data;

    arpt_mem #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    arpt_ctrl #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an item is in flight");

    a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> !req.ready)
        else $error("table write while idle");

    a_write_resp: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (rsp.valid && rsp.ok && rsp.status == ST_OK))
        else $error("table write without a successful response");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (32'(wr_addr) < TABLE_ENTRIES))
        else $error("table write beyond depth");

    a_ok_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.ok == (rsp.status == ST_OK)))
        else $error("ok flag disagrees with status");

endmodule

>>> sim/tb_address_range_permission_table_core.sv
// tb_address_range_permission_table_core: self-checking testbench for the range
// permission table, with a directed opening and a long randomised phase
// needs arpt_pkg, arpt_req_if, arpt_rsp_if and address_range_permission_table_core
`timescale 1ns / 1ps

module tb_address_range_permission_table_core;
    import arpt_pkg::*;

    localparam int    TABLE_ENTRIES = TABLE_ENTRIES_DEF;
    localparam int    RANDOM_ITEMS  = 800;
    localparam int    CYCLE_LIMIT   = 300000;
    localparam int    HOLD_AT       = 150;
    localparam int    HOLD_LEN      = 400;
    localparam int    QUIET_FROM    = 300;
    localparam int    QUIET_TO      = 450;
    localparam int    DRAIN_AT      = 550;
    localparam int    SETTLE_CYCLES = 40;
    localparam addr_t ALL_ONES      = '1;
    localparam addr_t TOP_BEGIN     = 64'hFFFF_FFFF_FFFF_FF00;

    typedef struct {
        action_t action;
        addr_t   address;
        addr_t   span_size;
        logic    want_write;
    } request_t;

    typedef struct {
        logic    ok;
        status_t status;
    } verdict_t;

    logic clk;
    logic rst_n;

    arpt_req_if req_if ();
    arpt_rsp_if rsp_if ();

    address_range_permission_table_core #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow of the range table
    logic  shadow_valid    [TABLE_ENTRIES] = '{default: 1'b0};
    addr_t shadow_begin    [TABLE_ENTRIES];
    addr_t shadow_end      [TABLE_ENTRIES];
    logic  shadow_writable [TABLE_ENTRIES];

    request_t pending_requests [$];
    verdict_t expected_verdicts [$];

    int       items_sent;
    int       results_seen;
    int       hold_left;
    logic     hold_done;
    int       cycle_count = 0;
    int       mismatch_count = 0;
    int       status_hits [6] = '{default: 0};

    logic     req_taken;
    int       sent_after;
    logic     tx_quiet;
    request_t next_request;
    verdict_t predicted;
    verdict_t oldest;

    function automatic status_t predict_status(action_t act, addr_t addr, addr_t size,
                                               logic wr);
        addr_t span_end;
        logic  bad_span;
        int    slot;
        span_end = addr + size;
        bad_span = (addr == '0) || (size == '0) || (addr > (ALL_ONES - size));
        slot     = -1;
        case (act)
            ACT_PUBLISH:
            begin
                if (bad_span)
                    return ST_BAD_ARGS;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (shadow_valid[i])
                    begin
                        if (addr < shadow_end[i] && shadow_begin[i] < span_end)
                            return ST_OVERLAP;
                    end
                    else if (slot < 0)
                        slot = i;
                end
                if (slot < 0)
                    return ST_FULL;
                shadow_valid[slot]    = 1'b1;
                shadow_begin[slot]    = addr;
                shadow_end[slot]      = span_end;
                shadow_writable[slot] = wr;
                return ST_OK;
            end
            ACT_REVOKE:
            begin
                if (addr == '0)
                    return ST_BAD_ARGS;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (shadow_valid[i] && shadow_begin[i] == addr)
                    begin
                        shadow_valid[i] = 1'b0;
                        return ST_OK;
                    end
                end
                return ST_NOT_FOUND;
            end
            ACT_VALIDATE:
            begin
                if (bad_span)
                    return ST_BAD_ARGS;
                for (int i = 0; i < TABLE_ENTRIES; i++)
                begin
                    if (shadow_valid[i] && shadow_begin[i] <= addr &&
                        span_end <= shadow_end[i] && (!wr || shadow_writable[i]))
                        return ST_OK;
                end
                return ST_NOT_COVERED;
            end
            default:
                return ST_BAD_ARGS;
        endcase
    endfunction

    task automatic add_request(action_t act, addr_t addr, addr_t size, logic wr);
        request_t r;
        r.action     = act;
        r.address    = addr;
        r.span_size  = size;
        r.want_write = wr;
        pending_requests = {pending_requests, r};
    endtask

    task automatic report_mismatch(string what, int exp_val, int got_val);
        if (mismatch_count < 100)
            $display("mismatch on response %0d: %s expected %0d got %0d",
                     results_seen, what, exp_val, got_val);
        mismatch_count++;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("FAILED: results differ");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid      <= 1'b0;
            req_if.action     <= ACT_PUBLISH;
            req_if.address    <= '0;
            req_if.span_size  <= '0;
            req_if.want_write <= 1'b0;
            items_sent        <= 0;
        end
        else
        begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken)
            begin
                predicted.status = predict_status(req_if.action, req_if.address,
                                                  req_if.span_size, req_if.want_write);
                predicted.ok = (predicted.status == ST_OK);
                status_hits[predicted.status]++;
                expected_verdicts = {expected_verdicts, predicted};
            end
            sent_after = items_sent + (req_taken ? 1 : 0);
            items_sent <= sent_after;
            if (!req_if.valid || req_taken)
            begin
                tx_quiet = (sent_after >= QUIET_FROM && sent_after < QUIET_TO) ? 1'b0 :
                           ($urandom_range(0, 99) < 20);
                if (pending_requests.size() != 0 && !tx_quiet &&
                    !(sent_after == DRAIN_AT && expected_verdicts.size() != 0))
                begin
                    next_request      = pending_requests.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.action     <= next_request.action;
                    req_if.address    <= next_request.address;
                    req_if.span_size  <= next_request.span_size;
                    req_if.want_write <= next_request.want_write;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // long receiver stall once the run is under way
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        else if (!hold_done && results_seen >= HOLD_AT)
        begin
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end
    end

    // response monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            results_seen <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_verdicts.size() == 0)
                    report_mismatch("unexpected transfer, status", -1, int'(rsp_if.status));
                else
                begin
                    oldest = expected_verdicts.pop_front();
                    if (rsp_if.ok !== oldest.ok)
                        report_mismatch("ok", int'(oldest.ok), int'(rsp_if.ok));
                    if (rsp_if.status !== oldest.status)
                        report_mismatch("status", int'(oldest.status), int'(rsp_if.status));
                end
            end
            rsp_if.ready <= (hold_left == 0) &&
                            ((results_seen >= QUIET_FROM && results_seen < QUIET_TO) ||
                             ($urandom_range(0, 99) >= 20));
        end
    end

    initial
    begin
        addr_t region_base [4];
        addr_t slot_addr;
        int    pick;

        rst_n = 1'b0;

        // directed opening
        add_request(ACT_PUBLISH,  64'h1000, 64'h100, 1'b1);
        add_request(ACT_PUBLISH,  TOP_BEGIN, 64'hFF, 1'b0);
        add_request(ACT_PUBLISH,  64'h10FF, 64'h1, 1'b0);
        add_request(ACT_PUBLISH,  64'h0, 64'h10, 1'b1);
        add_request(ACT_PUBLISH,  64'h5000, 64'h0, 1'b1);
        add_request(ACT_PUBLISH,  TOP_BEGIN, 64'h100, 1'b0);
        add_request(ACT_VALIDATE, TOP_BEGIN, 64'hFF, 1'b0);
        add_request(ACT_VALIDATE, TOP_BEGIN, 64'hFF, 1'b1);
        add_request(ACT_VALIDATE, 64'h1000, 64'h100, 1'b1);
        add_request(ACT_VALIDATE, 64'h1100, 64'h1, 1'b0);
        add_request(ACT_REVOKE,   64'h0, ALL_ONES, 1'b0);
        add_request(ACT_REVOKE,   64'h1001, 64'h0, 1'b1);
        add_request(action_t'(3), ALL_ONES, ALL_ONES, 1'b1);
        for (int i = 0; i < TABLE_ENTRIES - 2; i++)
            add_request(ACT_PUBLISH, 64'h2000 + addr_t'(i) * 64'h100, 64'h100, i[0]);
        add_request(ACT_PUBLISH,  64'h9000, 64'h10, 1'b1);
        add_request(ACT_REVOKE,   64'h1000, 64'h0, 1'b0);

        // random phase over a few regions so that ranges collide and revokes hit
        region_base[0] = 64'h0000_0000_0010_0000;
        region_base[1] = 64'hFFFF_FFFF_FFFF_C000;
        region_base[2] = ({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_0000) |
                         64'h0000_0001_0000_0000;
        region_base[3] = ({$urandom, $urandom} & 64'h7FFF_FFFF_FFFF_0000) |
                         64'h0000_0001_0000_0000;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            slot_addr = region_base[$urandom_range(0, 3)] +
                        addr_t'($urandom_range(0, 15)) * 64'h100;
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_request(ACT_PUBLISH,
                            slot_addr + (($urandom_range(0, 9) == 0) ?
                                         addr_t'($urandom_range(1, 255)) : '0),
                            ($urandom_range(0, 9) < 7) ? 64'h100 :
                                                         addr_t'($urandom_range(1, 768)),
                            1'($urandom_range(0, 1)));
            else if (pick < 62)
                add_request(ACT_REVOKE,
                            slot_addr + (($urandom_range(0, 4) == 0) ?
                                         addr_t'($urandom_range(1, 255)) : '0),
                            {$urandom, $urandom}, 1'($urandom_range(0, 1)));
            else if (pick < 92)
            begin
                if ($urandom_range(0, 3) == 0)
                    add_request(ACT_VALIDATE, slot_addr, 64'h100,
                                1'($urandom_range(0, 1)));
                else
                    add_request(ACT_VALIDATE, slot_addr + addr_t'($urandom_range(0, 255)),
                                addr_t'($urandom_range(1, 384)),
                                1'($urandom_range(0, 1)));
            end
            else
                add_request(action_t'($urandom_range(0, 3)),
                            ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom},
                            ($urandom_range(0, 3) == 0) ? '0 : {$urandom, $urandom},
                            1'($urandom_range(0, 1)));
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_requests.size() != 0 || req_if.valid)
            @(posedge clk);
        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (expected_verdicts.size() != 0)
            report_mismatch("responses still owed", 0, expected_verdicts.size());
        $display("covered %0d requests and %0d responses, %0d mismatches",
                 items_sent, results_seen, mismatch_count);
        $display("outcomes: ok %0d, bad args %0d, overlap %0d, not found %0d, full %0d, %s %0d",
                 status_hits[ST_OK], status_hits[ST_BAD_ARGS], status_hits[ST_OVERLAP],
                 status_hits[ST_NOT_FOUND], status_hits[ST_FULL], "not covered",
                 status_hits[ST_NOT_COVERED]);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
